// ----- rtl/clts_pkg.sv -----
// ----------------------------------------------------------------------------
// Cursor list package
// Word types, command and status codes and default sizes shared by the
// cursor list block.
// ----------------------------------------------------------------------------
package clts_pkg;

	// Default sizes of the two stacks and of one stored item.
	localparam int STACK_DEPTH = 16;
	localparam int ITEM_BITS   = 16;

	// Fixed widths of the word fields.
	localparam int VALUE_W = 16;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		CMD_MOVE_LEFT  = 2'd0,
		CMD_MOVE_RIGHT = 2'd1,
		CMD_DELETE     = 2'd2,
		CMD_INSERT     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_MOVE = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [VALUE_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [VALUE_W-1:0] active_item;
		logic               active_present;
		logic               list_empty;
		status_t            status;
		logic [COUNT_W-1:0] left_count;
		logic [COUNT_W-1:0] right_count;
	} rsp_t;

endpackage

// ----- rtl/cursor_list_two_stacks_top.sv -----
// ----------------------------------------------------------------------------
// Cursor list kept as two stacks around one active register
// Gap buffer: left stack, active item, right stack, one command per cycle.
// ----------------------------------------------------------------------------
// How to use this block:
// A command word (cmd and item_value) is taken on the request port at every
// rising edge where start is high and busy is low. Busy is always low, so a
// new command may be issued in every cycle, back to back, with no gaps.
// Commands move the cursor left or right, delete the active item, or insert
// item_value as the new active item (the old active item goes to the right).
// Exactly one result word follows each command, on the result port, in the
// cycle after the command was taken, and is marked by done for that single
// cycle. The sustained rate is one command per cycle; it is set by the single
// update of the cursor register and the two stack tops, which are held in
// flip-flops in front of each stack memory. Each stack memory is written at
// its push address and read on a pop at the entry below the cached pair,
// with the read data registered into the cached second-from-top register,
// so a pop never waits on the memory.
// The receiver cannot stall: it must take each result word when done is high.
// Reset clears the cursor, both depths and the done strobe; the stack
// memories are not cleared, since an entry is only used after it was pushed.
// ----------------------------------------------------------------------------
module cursor_list_two_stacks_top #(
	parameter int STACK_DEPTH = clts_pkg::STACK_DEPTH,
	parameter int ITEM_BITS   = clts_pkg::ITEM_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  clts_pkg::req_t request,
	output logic           done,
	output clts_pkg::rsp_t result
);

	// Depth counters must hold the depth itself; addresses only index it.
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	// Architectural state: cursor register and both stack depths.
	logic [ITEM_BITS-1:0] cursor_q;
	logic                 cursor_valid_q;
	logic [CNT_W-1:0]     l_cnt_q;
	logic [CNT_W-1:0]     r_cnt_q;

	// Each stack keeps its top entry and the entry below it in flip-flops.
	// The memory holds every pushed entry, the cached pair included.
	logic [ITEM_BITS-1:0] l_top_q;
	logic [ITEM_BITS-1:0] l_sub_q;
	logic [ITEM_BITS-1:0] r_top_q;
	logic [ITEM_BITS-1:0] r_sub_q;
	logic [ITEM_BITS-1:0] l_mem [STACK_DEPTH];
	logic [ITEM_BITS-1:0] r_mem [STACK_DEPTH];

	// Result register.
	clts_pkg::rsp_t       rsp_q;
	logic                 done_q;

	// Next-state values and stack operations for the word being taken.
	logic                 accept;
	logic [ITEM_BITS-1:0] ins_val;
	logic [ITEM_BITS-1:0] n_cursor;
	logic                 n_valid;
	logic [CNT_W-1:0]     n_l_cnt;
	logic [CNT_W-1:0]     n_r_cnt;
	clts_pkg::status_t    n_status;
	logic                 l_push;
	logic                 l_pop;
	logic                 r_push;
	logic                 r_pop;
	logic                 l_full;
	logic                 r_full;
	logic                 list_full;
	logic [CNT_W-1:0]     l_rd_ptr;
	logic [CNT_W-1:0]     r_rd_ptr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign ins_val   = ITEM_BITS'(request.item_value);
	assign l_full    = (l_cnt_q >= CNT_W'(STACK_DEPTH));
	assign r_full    = (r_cnt_q >= CNT_W'(STACK_DEPTH));
	assign list_full = ((CNT_W+1)'(l_cnt_q) + (CNT_W+1)'(r_cnt_q))
		>= (CNT_W+1)'(STACK_DEPTH);

	// The entry that becomes second-from-top after a pop sits three below
	// the current depth.
	assign l_rd_ptr = l_cnt_q - CNT_W'(3);
	assign r_rd_ptr = r_cnt_q - CNT_W'(3);

	always_comb begin
		n_cursor = cursor_q;
		n_valid  = cursor_valid_q;
		n_l_cnt  = l_cnt_q;
		n_r_cnt  = r_cnt_q;
		n_status = clts_pkg::ST_DONE;
		l_push   = 1'b0;
		l_pop    = 1'b0;
		r_push   = 1'b0;
		r_pop    = 1'b0;
		unique case (request.cmd)
			clts_pkg::CMD_MOVE_LEFT: begin
				// Right top becomes active, the active item goes left.
				if (r_cnt_q == '0 || l_full) begin
					n_status = clts_pkg::ST_NO_MOVE;
				end else begin
					l_push   = cursor_valid_q;
					r_pop    = 1'b1;
					n_cursor = r_top_q;
					n_valid  = 1'b1;
				end
			end
			clts_pkg::CMD_MOVE_RIGHT: begin
				if (l_cnt_q == '0 || r_full) begin
					n_status = clts_pkg::ST_NO_MOVE;
				end else begin
					r_push   = cursor_valid_q;
					l_pop    = 1'b1;
					n_cursor = l_top_q;
					n_valid  = 1'b1;
				end
			end
			clts_pkg::CMD_DELETE: begin
				// Refill from the right first, then from the left.
				if (cursor_valid_q) begin
					if (r_cnt_q != '0) begin
						r_pop    = 1'b1;
						n_cursor = r_top_q;
					end else if (l_cnt_q != '0) begin
						l_pop    = 1'b1;
						n_cursor = l_top_q;
					end else begin
						n_cursor = '0;
						n_valid  = 1'b0;
					end
				end
			end
			clts_pkg::CMD_INSERT: begin
				if (cursor_valid_q && (list_full || r_full)) begin
					n_status = clts_pkg::ST_FULL;
				end else begin
					r_push   = cursor_valid_q;
					n_cursor = ins_val;
					n_valid  = 1'b1;
				end
			end
			default: begin
				n_status = clts_pkg::ST_DONE;
			end
		endcase
		if (l_push) begin
			n_l_cnt = l_cnt_q + CNT_W'(1);
		end else if (l_pop) begin
			n_l_cnt = l_cnt_q - CNT_W'(1);
		end
		if (r_push) begin
			n_r_cnt = r_cnt_q + CNT_W'(1);
		end else if (r_pop) begin
			n_r_cnt = r_cnt_q - CNT_W'(1);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q       <= '0;
			cursor_valid_q <= 1'b0;
			l_cnt_q        <= '0;
			r_cnt_q        <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				cursor_q       <= n_cursor;
				cursor_valid_q <= n_valid;
				l_cnt_q        <= n_l_cnt;
				r_cnt_q        <= n_r_cnt;
			end
		end
	end

	// Left stack: memory write on push, registered read on pop.
	always_ff @(posedge clk) begin
		if (accept && l_push) begin
			l_mem[l_cnt_q[ADDR_W-1:0]] <= cursor_q;
			l_top_q                    <= cursor_q;
			l_sub_q                    <= l_top_q;
		end else if (accept && l_pop) begin
			l_top_q <= l_sub_q;
			l_sub_q <= l_mem[l_rd_ptr[ADDR_W-1:0]];
		end
	end

	// Right stack, same arrangement.
	always_ff @(posedge clk) begin
		if (accept && r_push) begin
			r_mem[r_cnt_q[ADDR_W-1:0]] <= cursor_q;
			r_top_q                    <= cursor_q;
			r_sub_q                    <= r_top_q;
		end else if (accept && r_pop) begin
			r_top_q <= r_sub_q;
			r_sub_q <= r_mem[r_rd_ptr[ADDR_W-1:0]];
		end
	end

	// Result word, built from the state after the command.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.active_item    <= n_valid ? clts_pkg::VALUE_W'(n_cursor) : '0;
			rsp_q.active_present <= n_valid;
			rsp_q.list_empty     <= !n_valid && n_l_cnt == '0 && n_r_cnt == '0;
			rsp_q.status         <= n_status;
			rsp_q.left_count     <= clts_pkg::COUNT_W'(n_l_cnt);
			rsp_q.right_count    <= clts_pkg::COUNT_W'(n_r_cnt);
		end
	end

	assign done   = done_q;
	assign result = rsp_q;

endmodule
